// ===== hdl/min_priority_queue_array_top_macros.svh =====
// assertion macros used by the checker file
`ifndef MIN_PRIORITY_QUEUE_ARRAY_TOP_MACROS_SVH
`define MIN_PRIORITY_QUEUE_ARRAY_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MPQA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MPQA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mpqa_pkg.sv =====
`default_nettype none
package mpqa_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int PRI_W = 8;
  localparam int PAY_W = 32;

  // command field codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    write_cell;
    logic    scan_init;
    logic    scan_step;
    logic    shift_pop;
    logic    res_load;
    status_t res_code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
    logic scan_last;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/min_priority_queue_array_top.sv =====
// channel   | signals                                  | handshake
// ----------+------------------------------------------+-------------------------
// request   | command, priority_req, payload           | start, taken when !busy
// result    | status, out_priority, out_payload        | done, one cycle, no stall
//
// insert: result strobed on the following cycle, next request
//   may follow at once
// remove from n entries: load, n - 1 compare steps through the
//   one scan port, then one shift of the cell row; empty remove behaves as insert
// rst is synchronous; it empties the queue and drops any pending result
// the result is shown for a single cycle and cannot be held off
`default_nettype none
module min_priority_queue_array_top import mpqa_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    command,
  input  wire logic [PRI_W-1:0]        priority_req,
  input  wire logic signed [PAY_W-1:0] payload,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [PRI_W-1:0]             out_priority,
  output logic signed [PAY_W-1:0]      out_payload
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  mpqa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // cell row, scan and result registers
  mpqa_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .priority_req (priority_req),
    .payload      (payload),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload)
  );

endmodule
`default_nettype wire

// ===== hdl/mpqa_dp.sv =====
`default_nettype none
module mpqa_dp import mpqa_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  output dp_sts_t                      sts,
  input  wire logic [PRI_W-1:0]        priority_req,
  input  wire logic signed [PAY_W-1:0] payload,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [PRI_W-1:0]             out_priority,
  output logic signed [PAY_W-1:0]      out_payload
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [PRI_W-1:0] cell_pri [CAPACITY];
  logic [PAY_W-1:0] cell_pay [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best_idx;
  logic [PRI_W-1:0] best_pri;
  logic [PAY_W-1:0] best_pay;
  logic [PRI_W-1:0] rd_pri;
  logic [PAY_W-1:0] rd_pay;

  // scan read port
  assign rd_pri = cell_pri[scan_idx];
  assign rd_pay = cell_pay[scan_idx];

  // status toward the controller
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CNT_W'(CAPACITY));
  assign sts.single    = (count == CNT_W'(1));
  assign sts.scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);

  // cell row: append at the tail, or close the gap above the removed cell
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.write_cell && (count == CNT_W'(i))) begin
        cell_pri[i] <= priority_req;
        cell_pay[i] <= payload;
      end else if (cmd.shift_pop && (i < CAPACITY - 1) && (IDX_W'(i) >= best_idx)) begin
        cell_pri[i] <= cell_pri[(i + 1) % CAPACITY];
        cell_pay[i] <= cell_pay[(i + 1) % CAPACITY];
      end
    end
  end

  // occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.write_cell) begin
      count <= count + CNT_W'(1);
    end else if (cmd.shift_pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // running minimum, strict compare keeps the earliest on ties
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx <= IDX_W'(1);
      best_idx <= '0;
      best_pri <= cell_pri[0];
      best_pay <= cell_pay[0];
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (rd_pri < best_pri) begin
        best_idx <= scan_idx;
        best_pri <= rd_pri;
        best_pay <= rd_pay;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_code;
      if (cmd.shift_pop) begin
        out_priority <= best_pri;
        out_payload  <= best_pay;
      end else begin
        out_priority <= '0;
        out_payload  <= '0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mpqa_ctrl.sv =====
`default_nettype none
module mpqa_ctrl import mpqa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    command,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         busy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    cmd.write_cell = 1'b0;
    cmd.scan_init  = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.shift_pop  = 1'b0;
    cmd.res_load   = 1'b0;
    cmd.res_code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_INSERT) begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.write_cell = 1'b1;
            end
          end else if (sts.empty) begin
            cmd.res_load = 1'b1;
            cmd.res_code = ST_EMPTY;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = sts.single ? S_SHIFT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_pop = 1'b1;
        cmd.res_load  = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/mpqa_checker.sv =====
`default_nettype none
`include "min_priority_queue_array_top_macros.svh"
module mpqa_checker import mpqa_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    command,
  input wire logic                    done,
  input wire logic [1:0]              status,
  input wire logic [PRI_W-1:0]        out_priority,
  input wire logic signed [PAY_W-1:0] out_payload
);

  logic ins_taken;
  logic res_ok;
  logic res_full;
  logic res_fail;
  logic res_blank;

  assign ins_taken = start && !busy && (command == CMD_INSERT);

  // result classes and empty result fields
  assign res_ok    = done && (status == ST_OK);
  assign res_full  = done && (status == ST_FULL);
  assign res_fail  = done && (status != ST_OK);
  assign res_blank = (out_priority == '0) && (out_payload == '0);

  // an insert transaction always answers on the next cycle
  `MPQA_ASSERT_NXT(a_insert_answers, ins_taken, done, "insert without result")

  // a full report only follows an insert transaction
  `MPQA_ASSERT_IMP(a_full_after_insert, res_full, $past(ins_taken), "stray full")

  // failed or insert results carry no entry
  `MPQA_ASSERT_IMP(a_zero_fields, res_fail || (done && $past(ins_taken)), res_blank, "stray data")

  // the end of a remove sequence delivers its result
  `MPQA_ASSERT_IMP(a_remove_answers, $fell(busy), res_ok, "remove without result")

endmodule

bind min_priority_queue_array_top mpqa_checker u_mpqa_checker (.*);
`default_nettype wire

// ===== test/tb_min_priority_queue_array_top.sv =====
`timescale 1ns / 100ps

module tb_min_priority_queue_array_top;
  import mpqa_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  // one expected result transaction
  typedef struct {
    status_t                    status;
    logic [PRI_W-1:0]           pri;
    logic signed [PAY_W-1:0]    pay;
  } queue_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       command = CMD_INSERT;
  logic [PRI_W-1:0]           priority_req = '0;
  logic signed [PAY_W-1:0]    payload = '0;
  logic                       busy;
  logic                       done;
  logic [1:0]                 status;
  logic [PRI_W-1:0]           out_priority;
  logic signed [PAY_W-1:0]    out_payload;

  // shadow copy of the queue contents, in arrival order
  logic [PRI_W-1:0]           shadow_pri [CAPACITY];
  logic signed [PAY_W-1:0]    shadow_pay [CAPACITY];
  int                         shadow_count = 0;
  queue_result_t              awaited_results [$];

  int error_count = 0;
  int results_checked = 0;
  int insert_count = 0;
  int full_count = 0;
  int remove_count = 0;
  int empty_count = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  min_priority_queue_array_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .priority_req(priority_req),
    .payload(payload),
    .done(done),
    .status(status),
    .out_priority(out_priority),
    .out_payload(out_payload)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // cycle counter and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // apply one accepted transaction to the shadow queue and record its result
  task automatic apply_to_shadow_queue(input logic cmd, input logic [PRI_W-1:0] pri,
                                       input logic signed [PAY_W-1:0] pay);
    queue_result_t res;
    int best;
    res.status = ST_OK;
    res.pri = '0;
    res.pay = '0;
    if (cmd == CMD_INSERT) begin
      insert_count++;
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
        full_count++;
      end else begin
        shadow_pri[shadow_count] = pri;
        shadow_pay[shadow_count] = pay;
        shadow_count++;
      end
    end else begin
      remove_count++;
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
        empty_count++;
      end else begin
        // earliest entry wins on equal priority
        best = 0;
        for (int i = 1; i < shadow_count; i++) begin
          if (shadow_pri[i] < shadow_pri[best]) best = i;
        end
        res.pri = shadow_pri[best];
        res.pay = shadow_pay[best];
        // close the gap, keeping arrival order
        for (int i = best; i + 1 < shadow_count; i++) begin
          shadow_pri[i] = shadow_pri[i + 1];
          shadow_pay[i] = shadow_pay[i + 1];
        end
        shadow_count--;
      end
    end
    awaited_results.push_back(res);
  endtask

  // idle length after a transaction: mostly none or short, now and then long
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // present one request and hold it until the block takes it
  task automatic send_request(input logic cmd, input logic [PRI_W-1:0] pri,
                              input logic signed [PAY_W-1:0] pay);
    int gap;
    gap = next_gap();
    if (!start) start <= 1'b1;
    command <= cmd;
    priority_req <= pri;
    payload <= pay;
    do @(posedge clk); while (busy);
    apply_to_shadow_queue(cmd, pri, pay);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d pri %0d data %0d",
                 $time, status, out_priority, out_payload);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
          error_count++;
        end
        if (out_priority !== want.pri) begin
          $display("%0t: out_priority mismatch, expected %0d, actual %0d",
                   $time, want.pri, out_priority);
          error_count++;
        end
        if (out_payload !== want.pay) begin
          $display("%0t: out_payload mismatch, expected %0d, actual %0d",
                   $time, want.pay, out_payload);
          error_count++;
        end
      end
    end
  end

  // remove from an empty queue right after reset
  task automatic test_remove_when_empty();
    send_request(CMD_REMOVE, 8'hff, 32'hffff_ffff);
  endtask

  // fill to capacity with extreme values and ties, then overflow once
  task automatic test_fill_and_overflow();
    logic [PRI_W-1:0] pri_list [CAPACITY];
    logic signed [PAY_W-1:0] pay_val;
    pri_list = '{8'd255, 8'd7, 8'd0, 8'd200, 8'd7, 8'd0, 8'd128, 8'd1,
                 8'd255, 8'd64, 8'd0, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2};
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: pay_val = 32'sh8000_0000;
        1: pay_val = 32'sh7fff_ffff;
        2: pay_val = -32'sd1;
        default: pay_val = 32'sd0;
      endcase
      if (i >= 8) pay_val = $urandom;
      send_request(CMD_INSERT, pri_list[i], pay_val);
    end
    send_request(CMD_INSERT, 8'd0, 32'sh1234_5678);
  endtask

  // pull the smallest entries, including three ties at priority zero
  task automatic test_min_and_ties();
    repeat (6) send_request(CMD_REMOVE, PRI_W'($urandom), $urandom);
  endtask

  // long random traffic swinging between empty and full
  task automatic test_random_traffic();
    bit filling;
    int r;
    logic cmd;
    logic [PRI_W-1:0] pri;
    logic signed [PAY_W-1:0] pay;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (shadow_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (shadow_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      cmd = ($urandom_range(0, 99) < (filling ? 80 : 20)) ? CMD_INSERT : CMD_REMOVE;
      r = $urandom_range(0, 9);
      if (r < 3) pri = PRI_W'($urandom_range(0, 3));
      else if (r < 5) pri = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else pri = PRI_W'($urandom_range(0, 255));
      r = $urandom_range(0, 19);
      if (r == 0) pay = 32'sh8000_0000;
      else if (r == 1) pay = 32'sh7fff_ffff;
      else pay = $urandom;
      send_request(cmd, pri, pay);
    end
    no_gaps = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_remove_when_empty();
    test_fill_and_overflow();
    test_min_and_ties();
    test_random_traffic();
    if (start) start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d inserts (%0d refused as full), %0d removes (%0d on empty queue)",
             insert_count, full_count, remove_count, empty_count);
    $display("tb: %0d results compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
